@@ rtl/nsfc_pkg.sv @@
// nsfc_pkg: shared types and constants for the newline stuffed frame codec
// no dependencies; used by every module under rtl
package nsfc_pkg;

	localparam int FRAME_LEN = 10;

	localparam logic [7:0] LF_BYTE     = 8'h0A;
	localparam logic [7:0] STUFF_BYTE  = 8'h1A;
	localparam logic [7:0] SEED        = 8'hA5;
	localparam logic [7:0] MASK_ALT    = 8'h01;
	localparam logic [7:0] STATUS_MASK = 8'hFE;

	localparam logic [3:0] LINE_MAX  = 4'd9;
	localparam logic [3:0] LINE_LONG = 4'd10;
	localparam logic [3:0] SER_COUNT = 4'(FRAME_LEN - 1);

	localparam logic OP_RX = 1'b0;
	localparam logic OP_TX = 1'b1;

	localparam logic [1:0] KIND_TX  = 2'd0;
	localparam logic [1:0] KIND_OK  = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	typedef logic [FRAME_LEN-1:0][7:0] frame_t;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  rx_byte;
		logic [15:0] tx_id;
		logic [31:0] tx_data;
		logic        tx_cmd;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic        last;
		logic [15:0] frame_id;
		logic [31:0] frame_data;
		logic [7:0]  peer_status;
		logic [7:0]  rx_error_count;
	} rsp_t;

	typedef struct packed {
		logic        fire;
		logic        err;
		logic [15:0] frame_id;
		logic [31:0] frame_data;
		logic [7:0]  peer_status;
		logic [7:0]  count;
	} rx_result_t;

endpackage

@@ rtl/newline_stuffed_frame_codec_top.sv @@
// a request is registered in req_s1 and its first result in the result register out_q
// throughput: one received byte per cycle when no frame is sent and any result can
// load; transmit gives ten result bytes, one per cycle while the single out_q loads
// reset: arst_n clears valids, serializer count, line length and error counter
// the line buffer holds no reset and needs no clearing pass
// depends on nsfc_pkg, nsfc_encoder, nsfc_tx_serializer, nsfc_rx_decoder
module newline_stuffed_frame_codec_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  nsfc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output nsfc_pkg::rsp_t rsp
);

	nsfc_pkg::req_t       req_s1;
	logic                 valid_s1;
	nsfc_pkg::rsp_t       out_q;
	logic                 out_valid_q;
	nsfc_pkg::frame_t     frame;
	nsfc_pkg::rx_result_t rx_res;
	nsfc_pkg::rsp_t       out_next;
	logic [7:0]           err_count;
	logic                 ser_busy;
	logic [7:0]           ser_head;
	logic                 ser_last;
	logic                 is_tx;
	logic                 out_load;
	logic                 consume;
	logic                 out_write;

	assign is_tx    = (req_s1.opcode == nsfc_pkg::OP_TX);
	assign out_load = !out_valid_q || rsp_ready;
	assign consume  = valid_s1 && !ser_busy && (is_tx ? out_load : (!rx_res.fire || out_load));
	assign out_write = (ser_busy && out_load) || (consume && (is_tx || rx_res.fire));
	assign req_ready = !valid_s1 || consume;

	nsfc_encoder u_encoder (
		.tx_id     (req_s1.tx_id),
		.tx_data   (req_s1.tx_data),
		.tx_cmd    (req_s1.tx_cmd),
		.err_count (err_count),
		.frame     (frame)
	);

	nsfc_tx_serializer u_serializer (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (consume && is_tx),
		.frame  (frame),
		.shift  (ser_busy && out_load),
		.busy   (ser_busy),
		.head   (ser_head),
		.last   (ser_last)
	);

	nsfc_rx_decoder u_rx_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (consume && !is_tx),
		.rx_byte   (req_s1.rx_byte),
		.result    (rx_res),
		.err_count (err_count)
	);

	always_comb begin
		out_next = '0;
		out_next.rx_error_count = err_count;
		if (ser_busy) begin
			out_next.kind    = nsfc_pkg::KIND_TX;
			out_next.tx_byte = ser_head;
			out_next.last    = ser_last;
		end else if (is_tx) begin
			out_next.kind    = nsfc_pkg::KIND_TX;
			out_next.tx_byte = frame[0];
		end else begin
			out_next.kind           = rx_res.err ? nsfc_pkg::KIND_ERR : nsfc_pkg::KIND_OK;
			out_next.frame_id       = rx_res.frame_id;
			out_next.frame_data     = rx_res.frame_data;
			out_next.peer_status    = rx_res.peer_status;
			out_next.rx_error_count = rx_res.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				valid_s1 <= 1'b1;
			end else if (consume) begin
				valid_s1 <= 1'b0;
			end
			if (out_write) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (out_write) begin
			out_q <= out_next;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_no_consume_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ser_busy |-> !consume)
		else $error("request taken while a frame is still being sent");
	a_tx_starts_ser: assert property (@(posedge clk) disable iff (!arst_n)
		consume && is_tx |=> ser_busy && out_valid_q)
		else $error("transmit transaction did not start the serializer");
	a_last_is_tx: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.last |-> rsp.kind == nsfc_pkg::KIND_TX && rsp.tx_byte == nsfc_pkg::LF_BYTE)
		else $error("last flag on a result that is not the closing line feed");

endmodule

@@ rtl/nsfc_encoder.sv @@
// nsfc_encoder: builds the ten wire bytes of a frame with lf stuffing and checksum
// depends on nsfc_pkg
module nsfc_encoder (
	input  logic [15:0]     tx_id,
	input  logic [31:0]     tx_data,
	input  logic            tx_cmd,
	input  logic [7:0]      err_count,
	output nsfc_pkg::frame_t frame
);

	logic [6:0][7:0] raw;
	logic [6:0][7:0] stuffed;
	logic [7:0]      mask;
	logic [7:0]      mask_w;
	logic [7:0]      sum;
	logic [7:0]      sum_w;

	always_comb begin
		raw[0] = tx_id[15:8];
		raw[1] = tx_id[7:0];
		raw[2] = tx_data[7:0];
		raw[3] = tx_data[15:8];
		raw[4] = tx_data[23:16];
		raw[5] = tx_data[31:24];
		raw[6] = (err_count & nsfc_pkg::STATUS_MASK) + {7'd0, tx_cmd};
		mask = 8'd0;
		for (int i = 0; i < 7; i++) begin
			if (raw[i] == nsfc_pkg::LF_BYTE) begin
				stuffed[i] = nsfc_pkg::STUFF_BYTE;
				mask[3'(7 - i)] = 1'b1;
			end else begin
				stuffed[i] = raw[i];
			end
		end
		mask_w = (mask == nsfc_pkg::LF_BYTE) ? nsfc_pkg::MASK_ALT : mask;
		sum = nsfc_pkg::SEED ^ mask_w;
		for (int i = 0; i < 7; i++) begin
			sum = sum ^ stuffed[i];
		end
		sum_w = (sum == nsfc_pkg::LF_BYTE) ? nsfc_pkg::STUFF_BYTE : sum;
		for (int i = 0; i < 7; i++) begin
			frame[i] = stuffed[i];
		end
		frame[7] = mask_w;
		frame[8] = sum_w;
		frame[9] = nsfc_pkg::LF_BYTE;
	end

endmodule

@@ rtl/nsfc_tx_serializer.sv @@
// nsfc_tx_serializer: holds the remaining bytes of an encoded frame and shifts them out
// depends on nsfc_pkg
module nsfc_tx_serializer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  nsfc_pkg::frame_t frame,
	input  logic             shift,
	output logic             busy,
	output logic [7:0]       head,
	output logic             last
);

	logic [nsfc_pkg::FRAME_LEN-2:0][7:0] ser_q;
	logic [3:0]                          cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
		end else if (load) begin
			cnt_q <= nsfc_pkg::SER_COUNT;
		end else if (shift) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ser_q <= frame[nsfc_pkg::FRAME_LEN-1:1];
		end else if (shift) begin
			ser_q <= {8'h00, ser_q[nsfc_pkg::FRAME_LEN-2:1]};
		end
	end

	assign busy = (cnt_q != 4'd0);
	assign head = ser_q[0];
	assign last = (cnt_q == 4'd1);

endmodule

@@ rtl/nsfc_rx_decoder.sv @@
// nsfc_rx_decoder: line buffer, line length and error counter, decodes ten byte lines
// depends on nsfc_pkg
module nsfc_rx_decoder (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_en,
	input  logic [7:0]             rx_byte,
	output nsfc_pkg::rx_result_t   result,
	output logic [7:0]             err_count
);

	logic [7:0] buf_q [9];
	logic [3:0] len_q;
	logic [7:0] count_q;
	logic       is_lf;
	logic [7:0] sum;
	logic [7:0] got;
	logic [7:0] mask;
	logic [6:0][7:0] d;

	assign is_lf = (rx_byte == nsfc_pkg::LF_BYTE);

	always_comb begin
		sum = nsfc_pkg::SEED;
		for (int i = 0; i < 8; i++) begin
			sum = sum ^ buf_q[i];
		end
		got = (buf_q[8] == nsfc_pkg::STUFF_BYTE) ? nsfc_pkg::LF_BYTE : buf_q[8];
		mask = (buf_q[7] == nsfc_pkg::MASK_ALT) ? nsfc_pkg::LF_BYTE : buf_q[7];
		for (int i = 0; i < 7; i++) begin
			d[i] = mask[3'(7 - i)] ? nsfc_pkg::LF_BYTE : buf_q[i];
		end
		result.fire = is_lf && (len_q == nsfc_pkg::LINE_MAX);
		result.err  = (sum != got);
		if (result.err) begin
			result.frame_id    = 16'd0;
			result.frame_data  = 32'd0;
			result.peer_status = 8'd0;
			result.count       = count_q + 8'd1;
		end else begin
			result.frame_id    = {d[0], d[1]};
			result.frame_data  = {d[5], d[4], d[3], d[2]};
			result.peer_status = d[6];
			result.count       = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= 4'd0;
			count_q <= 8'd0;
		end else if (byte_en) begin
			if (is_lf) begin
				len_q <= 4'd0;
				if (result.fire && result.err) begin
					count_q <= count_q + 8'd1;
				end
			end else if (len_q < nsfc_pkg::LINE_LONG) begin
				len_q <= len_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_en && !is_lf && (len_q < nsfc_pkg::LINE_MAX)) begin
			buf_q[len_q] <= rx_byte;
		end
	end

	assign err_count = count_q;

	a_count_bump: assert property (@(posedge clk) disable iff (!arst_n)
		byte_en && result.fire && result.err |=> count_q == $past(count_q) + 8'd1)
		else $error("error counter missed a checksum failure");
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(byte_en && result.fire && result.err) |=> $stable(count_q))
		else $error("error counter moved without a checksum failure");
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= nsfc_pkg::LINE_LONG)
		else $error("line length beyond saturation");

endmodule
